// ----- rtl/bamf_pkg.sv -----
// shared types and constants for the advertising manufacturer filter
package bamf_pkg;

	localparam int unsigned MaxPayloadBytes = 255;

	localparam int unsigned CfgIndexW = 8;
	localparam logic [CfgIndexW-1:0] RegMatchType    = 8'd0;
	localparam logic [CfgIndexW-1:0] RegMatchPattern = 8'd1;

	localparam logic [7:0]  MatchTypeReset    = 8'hFF;
	localparam logic [23:0] MatchPatternReset = 24'h4C0002;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [47:0] device_mac;
	} in_item_t;

	typedef struct packed {
		logic        match;
		logic        type_found;
		logic [47:0] match_mac;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  match_type;
		logic [23:0] match_pattern;
	} cfg_t;

	typedef struct packed {
		logic match;
		logic type_found;
	} verdict_t;

endpackage

// ----- rtl/bamf_parse_core.sv -----
// structure walker, pattern compare and per-packet state
module bamf_parse_core #(
	parameter int unsigned MAX_PAYLOAD_BYTES = bamf_pkg::MaxPayloadBytes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  bamf_pkg::cfg_t     cfg,
	output bamf_pkg::verdict_t verdict
);

	localparam int unsigned PosW = $clog2(MAX_PAYLOAD_BYTES + 1);

	localparam logic [1:0] PH_LENGTH = 2'd0;
	localparam logic [1:0] PH_TYPE   = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;
	localparam logic [1:0] PH_CMP    = 2'd3;

	logic [1:0]      phase_q, phase_d;
	logic [7:0]      left_q, left_d;
	logic [1:0]      cap_q, cap_d;
	logic            good_q, good_d;
	logic            done_q, done_d;
	logic            found_q, found_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [7:0]      want;
	logic            take;

	always_comb begin
		case (cap_q)
			2'd0:    want = cfg.match_pattern[23:16];
			2'd1:    want = cfg.match_pattern[15:8];
			default: want = cfg.match_pattern[7:0];
		endcase
	end

	assign take = pos_q < PosW'(MAX_PAYLOAD_BYTES);

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		cap_d   = cap_q;
		good_d  = good_q;
		done_d  = done_q;
		found_d = found_q;
		pos_d   = pos_q;
		if (take) begin
			pos_d = pos_q + PosW'(1);
			if (!done_q || phase_q == PH_CMP) begin
				case (phase_q)
					PH_LENGTH: begin
						if (data_byte != 8'd0) begin
							left_d  = data_byte;
							phase_d = PH_TYPE;
						end
					end
					PH_TYPE: begin
						if (!done_q && data_byte == cfg.match_type) begin
							done_d = 1'b1;
							if (left_q >= 8'd2) begin
								found_d = 1'b1;
								cap_d   = 2'd0;
								good_d  = 1'b1;
								phase_d = PH_CMP;
							end
						end else begin
							left_d  = left_q - 8'd1;
							phase_d = (left_q == 8'd1) ? PH_LENGTH : PH_SKIP;
						end
					end
					PH_SKIP: begin
						left_d = left_q - 8'd1;
						if (left_q == 8'd1) begin
							phase_d = PH_LENGTH;
						end
					end
					default: begin
						if (cap_q != 2'd3) begin
							if (data_byte != want) begin
								good_d = 1'b0;
							end
							cap_d = cap_q + 2'd1;
						end
					end
				endcase
			end
		end
	end

	assign verdict.match      = found_d && good_d && (cap_d == 2'd3);
	assign verdict.type_found = found_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			left_q  <= 8'd0;
			cap_q   <= 2'd0;
			good_q  <= 1'b1;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q <= PH_LENGTH;
				left_q  <= 8'd0;
				cap_q   <= 2'd0;
				good_q  <= 1'b1;
				done_q  <= 1'b0;
				found_q <= 1'b0;
				pos_q   <= '0;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
				cap_q   <= cap_d;
				good_q  <= good_d;
				done_q  <= done_d;
				found_q <= found_d;
				pos_q   <= pos_d;
			end
		end
	end

endmodule

// ----- rtl/ble_adv_manufacturer_filter_unit.sv -----
// top level of the advertising manufacturer filter: input stage, config, result register
// a result enters the result register when its last byte advances out of the input stage register
// throughput: one byte item per cycle, limited only by a stalled result register
// the per-packet parse state updates between input and result registers
// reset: asynchronous, clears parse state and valids, config returns to 0xFF / 0x4C0002
module ble_adv_manufacturer_filter_unit #(
	parameter int unsigned MAX_PAYLOAD_BYTES = bamf_pkg::MaxPayloadBytes
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bamf_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bamf_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bamf_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [23:0]                        cfg_data
);

	logic                valid_s1;
	bamf_pkg::in_item_t  item_s1;
	logic                advance;
	logic                out_valid_q;
	bamf_pkg::out_item_t out_data_q;
	bamf_pkg::cfg_t      cfg_q;
	bamf_pkg::verdict_t  verdict;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_type    <= bamf_pkg::MatchTypeReset;
			cfg_q.match_pattern <= bamf_pkg::MatchPatternReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bamf_pkg::RegMatchType:    cfg_q.match_type    <= cfg_data[7:0];
				bamf_pkg::RegMatchPattern: cfg_q.match_pattern <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!item_s1.last_byte || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_data;
		end
	end

	bamf_parse_core #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.cfg       (cfg_q),
		.verdict   (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			out_data_q.match      <= verdict.match;
			out_data_q.type_found <= verdict.type_found;
			out_data_q.match_mac  <= item_s1.device_mac;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- tb/sv/ble_adv_manufacturer_filter_unit_tb.sv -----
// testbench for the advertising manufacturer filter: directed, then random packets
`timescale 1ns / 100ps

module ble_adv_manufacturer_filter_unit_tb;

	localparam int unsigned CLK_PERIOD = 12;
	localparam int unsigned RESET_CYCLES = 5;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned NUM_PHASES = 6;
	localparam int unsigned BYTES_PER_PHASE = 150;
	localparam logic [bamf_pkg::CfgIndexW-1:0] REG_UNMAPPED = 8'hFF;

	typedef enum logic [1:0] {SEEK_LEN, SEEK_TYPE, SKIP_VAL, CMP_PAT} parse_e;

	typedef struct packed {
		logic [7:0]         data;
		logic               last;
		logic [47:0]        mac;
		logic               fixed;
		bamf_pkg::verdict_t v;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bamf_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bamf_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bamf_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// filter prediction state
	logic [7:0] pred_type = bamf_pkg::MatchTypeReset;
	logic [23:0] pred_pattern = bamf_pkg::MatchPatternReset;
	parse_e parse_ph = SEEK_LEN;
	logic [7:0] struct_left = '0;
	logic [1:0] cmp_count = '0;
	logic cmp_good = 1'b1;
	logic type_seen = 1'b0;
	logic type_long = 1'b0;
	int unsigned pkt_pos = 0;

	bamf_pkg::out_item_t verdict_q[$];
	bamf_pkg::out_item_t head;
	logic [7:0] payload_q[$];
	int unsigned err_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned stall_len;
	bit calm = 1'b0;
	int unsigned phase;

	dir_row_t dir_rows [25] = '{
		'{8'h02, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h01, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h06, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h05, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'hFF, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h4C, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h02, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h15, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 2'b11},
		// padding, pattern running into the next structure
		'{8'h00, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h02, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'hFF, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h4C, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h02, 1'b1, 48'h0, 1'b1, 2'b11},
		// target with length one
		'{8'h01, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'hFF, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h00, 1'b1, 48'h0123_4567_89AB, 1'b1, 2'b00},
		// packet ends inside the pattern
		'{8'h03, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'hFF, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h4C, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h00, 1'b1, 48'hA5A5_A5A5_A5A5, 1'b1, 2'b01},
		// no target structure
		'{8'h02, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'h01, 1'b0, 48'h0, 1'b0, 2'b00},
		'{8'hFF, 1'b1, 48'h5A5A_5A5A_5A5A, 1'b1, 2'b00}
	};

	ble_adv_manufacturer_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	function automatic int unsigned pick_gap();
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		case (parse_ph)
			SEEK_LEN: begin
				if (b != 8'h00) begin
					struct_left = b;
					parse_ph = SEEK_TYPE;
				end
			end
			SEEK_TYPE: begin
				if (!type_seen && b == pred_type) begin
					type_seen = 1'b1;
					if (struct_left >= 8'd2) begin
						type_long = 1'b1;
						cmp_count = '0;
						cmp_good = 1'b1;
						parse_ph = CMP_PAT;
					end
				end else begin
					struct_left = struct_left - 8'd1;
					parse_ph = (struct_left == 8'd0) ? SEEK_LEN : SKIP_VAL;
				end
			end
			SKIP_VAL: begin
				struct_left = struct_left - 8'd1;
				if (struct_left == 8'd0)
					parse_ph = SEEK_LEN;
			end
			default: begin
				if (cmp_count < 2'd3) begin
					if (b != pred_pattern[8 * (2 - int'(cmp_count)) +: 8])
						cmp_good = 1'b0;
					cmp_count = cmp_count + 2'd1;
				end
			end
		endcase
	endfunction

	// returns 1 when the byte closes a packet and res holds its verdict
	function automatic bit filter_byte(input bamf_pkg::in_item_t it,
			output bamf_pkg::out_item_t res);
		res = '0;
		if (pkt_pos < bamf_pkg::MaxPayloadBytes) begin
			pkt_pos++;
			if (!type_seen || parse_ph == CMP_PAT)
				parse_byte(it.data_byte);
		end
		if (!it.last_byte)
			return 1'b0;
		res.match = type_long && cmp_good && cmp_count == 2'd3;
		res.type_found = type_long;
		res.match_mac = it.device_mac;
		parse_ph = SEEK_LEN;
		struct_left = '0;
		cmp_count = '0;
		cmp_good = 1'b1;
		type_seen = 1'b0;
		type_long = 1'b0;
		pkt_pos = 0;
		return 1'b1;
	endfunction

	task automatic feed(input bamf_pkg::in_item_t it, input logic fixed,
			input bamf_pkg::verdict_t v);
		bamf_pkg::out_item_t res;
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (filter_byte(it, res)) begin
			if (fixed) begin
				res.match = v.match;
				res.type_found = v.type_found;
			end
			verdict_q.push_back(res);
		end
	endtask

	task automatic write_reg(input logic [bamf_pkg::CfgIndexW-1:0] idx,
			input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			bamf_pkg::RegMatchType: pred_type = val[7:0];
			bamf_pkg::RegMatchPattern: pred_pattern = val;
			default: ;
		endcase
	endtask

	task automatic load_filter(input logic [7:0] typ, input logic [23:0] pat);
		if ($urandom_range(0, 1) == 1) begin
			write_reg(bamf_pkg::RegMatchPattern, pat);
			write_reg(bamf_pkg::RegMatchType, {16'h0, typ});
		end else begin
			write_reg(bamf_pkg::RegMatchType, {16'h0, typ});
			write_reg(bamf_pkg::RegMatchPattern, pat);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_structure();
		int unsigned len;
		if ($urandom_range(0, 4) == 0) begin
			payload_q.push_back(8'h00);
			return;
		end
		len = $urandom_range(1, 6);
		payload_q.push_back(8'(len));
		repeat (len) payload_q.push_back(8'($urandom));
	endtask

	task automatic build_packet();
		int unsigned kind, n, len, flip, cut, k;
		logic [7:0] pat_byte;
		payload_q = {};
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			n = $urandom_range(1, 20);
			repeat (n) payload_q.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 3)) add_structure();
		if (kind < 90 || kind >= 96) begin
			len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
			payload_q.push_back(8'(len));
			payload_q.push_back(pred_type);
			if (len > 1) begin
				flip = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 3;
				for (k = 0; k < 3; k++) begin
					pat_byte = pred_pattern[8 * (2 - k) +: 8];
					if (k == flip)
						pat_byte = pat_byte ^ 8'($urandom_range(1, 255));
					payload_q.push_back(pat_byte);
				end
				for (k = 4; k < len; k++)
					payload_q.push_back(8'($urandom));
			end
		end
		repeat ($urandom_range(0, 2)) add_structure();
		if (kind >= 96) begin
			n = $urandom_range(250, 300);
			while (payload_q.size() < n)
				payload_q.push_back(8'($urandom));
		end else if ($urandom_range(0, 6) == 0 && payload_q.size() > 1) begin
			cut = $urandom_range(1, payload_q.size() - 1);
			payload_q = payload_q[0:cut-1];
		end
		if (payload_q.size() == 0)
			payload_q.push_back(8'($urandom));
	endtask

	task automatic send_packet();
		bamf_pkg::in_item_t it;
		foreach (payload_q[i]) begin
			it.data_byte = payload_q[i];
			it.last_byte = (i == payload_q.size() - 1);
			it.device_mac = {16'($urandom), $urandom};
			feed(it, 1'b0, 2'b00);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
		end else begin
			stall_len = pick_gap();
			if (stall_len != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_len - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result item: match %0d type_found %0d match_mac %h",
					out_data.match, out_data.type_found, out_data.match_mac);
				err_count++;
			end else begin
				head = verdict_q.pop_front();
				if (out_data.match !== head.match) begin
					$error("match: expected %0d, actual %0d", head.match, out_data.match);
					err_count++;
				end
				if (out_data.type_found !== head.type_found) begin
					$error("type_found: expected %0d, actual %0d",
						head.type_found, out_data.type_found);
					err_count++;
				end
				if (out_data.match_mac !== head.match_mac) begin
					$error("match_mac: expected %h, actual %h", head.match_mac, out_data.match_mac);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[r])
			feed('{dir_rows[r].data, dir_rows[r].last, dir_rows[r].mac},
				dir_rows[r].fixed, dir_rows[r].v);
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			case (phase)
				0: load_filter(8'h00, 24'h000000);
				1: load_filter(8'hFF, 24'hFFFFFF);
				3: load_filter(bamf_pkg::MatchTypeReset, bamf_pkg::MatchPatternReset);
				4: begin
					write_reg(REG_UNMAPPED, 24'($urandom));
					load_filter(8'($urandom), 24'($urandom));
				end
				default: load_filter(8'($urandom), 24'($urandom));
			endcase
			calm = (phase == 2);
			while (items_sent < 25 + (phase + 1) * BYTES_PER_PHASE) begin
				build_packet();
				send_packet();
			end
		end
		calm = 1'b0;
		settle();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
